/* src/pfs_pkg.sv */
`timescale 1ns / 1ps

package pfs_pkg;

    localparam int POS_W   = 24;
    localparam int DIFF_W  = POS_W + 1;
    localparam int MAG_W   = POS_W;
    localparam int ACC_W   = 2 * MAG_W + 1;
    localparam int D2_W    = ACC_W + 1;
    localparam int ROOT_W  = D2_W / 2;
    localparam int SREM_W  = ROOT_W + 1;
    localparam int SPEED_W = 17;
    localparam int SCALE_W = ROOT_W + SPEED_W;
    localparam int FRAC_W  = 16;
    localparam int QUO_W   = SCALE_W - FRAC_W;
    localparam int CNT_W   = 6;

    localparam logic [SPEED_W-1:0] SPEED_ONE    = 17'h10000;
    localparam logic [ACC_W-1:0]   ONE_PIXEL_SQ = 49'd65536;
    localparam logic [ROOT_W-1:0]  ONE_PIXEL    = 25'd256;
    localparam logic [POS_W-1:0]   POS_MAX      = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0]   POS_MIN      = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_JUMP     = 2'd1,
        OP_SHIFT    = 2'd2,
        OP_RETARGET = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_PUBLISH
    } ctl_state_t;

    typedef enum logic [3:0] {
        TK_IDLE,
        TK_SQUARE,
        TK_CHECK,
        TK_ROOT,
        TK_SCALE,
        TK_FRAME,
        TK_MUL,
        TK_DIV,
        TK_APPLY
    } tick_state_t;

endpackage

/* src/pfs_tick.sv */
`timescale 1ns / 1ps

module pfs_tick import pfs_pkg::*; #(
    parameter int FRAME_RATE = 60
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [POS_W-1:0] cur_x,
    input  logic signed [POS_W-1:0] cur_y,
    input  logic signed [POS_W-1:0] goal_x,
    input  logic signed [POS_W-1:0] goal_y,
    input  logic [SPEED_W-1:0]      speed,
    output logic                    done,
    output logic signed [POS_W-1:0] new_x,
    output logic signed [POS_W-1:0] new_y
);

    localparam int FR_W = $clog2(FRAME_RATE) + 1;
    localparam logic [FR_W:0] FR_DIV = (FR_W + 1)'(FRAME_RATE);

    tick_state_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               sgn_x_reg, sgn_x_next, sgn_y_reg, sgn_y_next;
    logic [MAG_W-1:0]   mag_x_reg, mag_x_next, mag_y_reg, mag_y_next;
    logic [MAG_W-1:0]   msh_x_reg, msh_x_next, msh_y_reg, msh_y_next;
    logic [ACC_W-1:0]   acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic [ROOT_W-1:0]  rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [D2_W-1:0]    d2_reg, d2_next;
    logic [SREM_W-1:0]  srem_reg, srem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [SPEED_W-1:0] spd_reg, spd_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [QUO_W-1:0]   fq_reg, fq_next;
    logic [FR_W-1:0]    frem_reg, frem_next;
    logic [ROOT_W-1:0]  v_reg, v_next;
    logic               snap_reg, snap_next;
    logic               done_reg, done_next;
    logic [POS_W-1:0]   res_x_reg, res_x_next, res_y_reg, res_y_next;

    logic [DIFF_W-1:0]  dx, dy, abs_x, abs_y;
    logic [ROOT_W-1:0]  mult_x, mult_y;
    logic [ACC_W-1:0]   acc_add_x, acc_add_y, d2_sum;
    logic [SREM_W+1:0]  root_t, root_try, root_diff;
    logic               root_ge;
    logic [SCALE_W-1:0] scale_sum;
    logic [FR_W:0]      fr_t, fr_diff;
    logic               fr_ge;
    logic [QUO_W-1:0]   fq_shift;
    logic [ROOT_W-1:0]  v_calc;
    logic [ROOT_W:0]    div_den, div_t_x, div_t_y, div_diff_x, div_diff_y;
    logic               div_ge_x, div_ge_y;
    logic [DIFF_W-1:0]  step_x, step_y, sum_x, sum_y;

    assign dx    = {goal_x[POS_W-1], goal_x} - {cur_x[POS_W-1], cur_x};
    assign dy    = {goal_y[POS_W-1], goal_y} - {cur_y[POS_W-1], cur_y};
    assign abs_x = dx[DIFF_W-1] ? -dx : dx;
    assign abs_y = dy[DIFF_W-1] ? -dy : dy;

    assign mult_x    = (state_reg == TK_MUL) ? v_reg : {1'b0, mag_x_reg};
    assign mult_y    = (state_reg == TK_MUL) ? v_reg : {1'b0, mag_y_reg};
    assign acc_add_x = {acc_x_reg[ACC_W-2:0], 1'b0}
                     + (msh_x_reg[MAG_W-1] ? ACC_W'(mult_x) : '0);
    assign acc_add_y = {acc_y_reg[ACC_W-2:0], 1'b0}
                     + (msh_y_reg[MAG_W-1] ? ACC_W'(mult_y) : '0);
    assign d2_sum    = acc_x_reg + acc_y_reg;

    assign root_t    = {srem_reg, d2_reg[D2_W-1 -: 2]};
    assign root_try  = {1'b0, root_reg, 2'b01};
    assign root_ge   = root_t >= root_try;
    assign root_diff = root_t - root_try;

    assign scale_sum = {scale_reg[SCALE_W-2:0], 1'b0}
                     + (spd_reg[SPEED_W-1] ? SCALE_W'(root_reg) : '0);

    assign fr_t     = {frem_reg, fq_reg[QUO_W-1]};
    assign fr_ge    = fr_t >= FR_DIV;
    assign fr_diff  = fr_t - FR_DIV;
    assign fq_shift = {fq_reg[QUO_W-2:0], fr_ge};
    assign v_calc   = (fq_shift < QUO_W'(ONE_PIXEL)) ? ONE_PIXEL : fq_shift[ROOT_W-1:0];

    assign div_den    = {1'b0, root_reg};
    assign div_t_x    = {rem_x_reg, acc_x_reg[ACC_W-1]};
    assign div_t_y    = {rem_y_reg, acc_y_reg[ACC_W-1]};
    assign div_ge_x   = div_t_x >= div_den;
    assign div_ge_y   = div_t_y >= div_den;
    assign div_diff_x = div_t_x - div_den;
    assign div_diff_y = div_t_y - div_den;

    assign step_x = sgn_x_reg ? -{1'b0, acc_x_reg[MAG_W-1:0]} : {1'b0, acc_x_reg[MAG_W-1:0]};
    assign step_y = sgn_y_reg ? -{1'b0, acc_y_reg[MAG_W-1:0]} : {1'b0, acc_y_reg[MAG_W-1:0]};
    assign sum_x  = {cur_x[POS_W-1], cur_x} + step_x;
    assign sum_y  = {cur_y[POS_W-1], cur_y} + step_y;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TK_IDLE:
            begin
                if (start)
                begin
                    state_next = TK_SQUARE;
                end
            end
            TK_SQUARE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = TK_CHECK;
                end
            end
            TK_CHECK:
            begin
                state_next = (d2_sum <= ONE_PIXEL_SQ) ? TK_APPLY : TK_ROOT;
            end
            TK_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = TK_SCALE;
                end
            end
            TK_SCALE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = TK_FRAME;
                end
            end
            TK_FRAME:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = TK_MUL;
                end
            end
            TK_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = TK_DIV;
                end
            end
            TK_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = TK_APPLY;
                end
            end
            TK_APPLY:
            begin
                state_next = TK_IDLE;
            end
            default:
            begin
                state_next = TK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next   = cnt_reg - 1'b1;
        sgn_x_next = sgn_x_reg;
        sgn_y_next = sgn_y_reg;
        mag_x_next = mag_x_reg;
        mag_y_next = mag_y_reg;
        msh_x_next = msh_x_reg;
        msh_y_next = msh_y_reg;
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        d2_next    = d2_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        spd_next   = spd_reg;
        scale_next = scale_reg;
        fq_next    = fq_reg;
        frem_next  = frem_reg;
        v_next     = v_reg;
        snap_next  = snap_reg;
        done_next  = 1'b0;
        res_x_next = res_x_reg;
        res_y_next = res_y_reg;
        unique case (state_reg)
            TK_IDLE:
            begin
                cnt_next   = CNT_W'(MAG_W - 1);
                sgn_x_next = dx[DIFF_W-1];
                sgn_y_next = dy[DIFF_W-1];
                mag_x_next = abs_x[MAG_W-1:0];
                mag_y_next = abs_y[MAG_W-1:0];
                msh_x_next = abs_x[MAG_W-1:0];
                msh_y_next = abs_y[MAG_W-1:0];
                acc_x_next = '0;
                acc_y_next = '0;
            end
            TK_SQUARE:
            begin
                acc_x_next = acc_add_x;
                acc_y_next = acc_add_y;
                msh_x_next = {msh_x_reg[MAG_W-2:0], 1'b0};
                msh_y_next = {msh_y_reg[MAG_W-2:0], 1'b0};
            end
            TK_CHECK:
            begin
                cnt_next  = CNT_W'(ROOT_W - 1);
                snap_next = d2_sum <= ONE_PIXEL_SQ;
                d2_next   = {1'b0, d2_sum};
                srem_next = '0;
                root_next = '0;
                spd_next  = speed;
            end
            TK_ROOT:
            begin
                d2_next   = {d2_reg[D2_W-3:0], 2'b00};
                srem_next = root_ge ? root_diff[SREM_W-1:0] : root_t[SREM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], root_ge};
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(SPEED_W - 1);
                    scale_next = '0;
                end
            end
            TK_SCALE:
            begin
                scale_next = scale_sum;
                spd_next   = {spd_reg[SPEED_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    cnt_next  = CNT_W'(QUO_W - 1);
                    fq_next   = scale_sum[SCALE_W-1:FRAC_W];
                    frem_next = '0;
                end
            end
            TK_FRAME:
            begin
                frem_next = fr_ge ? fr_diff[FR_W-1:0] : fr_t[FR_W-1:0];
                fq_next   = fq_shift;
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(MAG_W - 1);
                    v_next     = v_calc;
                    msh_x_next = mag_x_reg;
                    msh_y_next = mag_y_reg;
                    acc_x_next = '0;
                    acc_y_next = '0;
                end
            end
            TK_MUL:
            begin
                acc_x_next = acc_add_x;
                acc_y_next = acc_add_y;
                msh_x_next = {msh_x_reg[MAG_W-2:0], 1'b0};
                msh_y_next = {msh_y_reg[MAG_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(ACC_W - 1);
                    rem_x_next = '0;
                    rem_y_next = '0;
                end
            end
            TK_DIV:
            begin
                rem_x_next = div_ge_x ? div_diff_x[ROOT_W-1:0] : div_t_x[ROOT_W-1:0];
                rem_y_next = div_ge_y ? div_diff_y[ROOT_W-1:0] : div_t_y[ROOT_W-1:0];
                acc_x_next = {acc_x_reg[ACC_W-2:0], div_ge_x};
                acc_y_next = {acc_y_reg[ACC_W-2:0], div_ge_y};
            end
            TK_APPLY:
            begin
                done_next  = 1'b1;
                res_x_next = snap_reg ? goal_x : sum_x[POS_W-1:0];
                res_y_next = snap_reg ? goal_y : sum_y[POS_W-1:0];
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TK_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        sgn_x_reg <= sgn_x_next;
        sgn_y_reg <= sgn_y_next;
        mag_x_reg <= mag_x_next;
        mag_y_reg <= mag_y_next;
        msh_x_reg <= msh_x_next;
        msh_y_reg <= msh_y_next;
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        d2_reg    <= d2_next;
        srem_reg  <= srem_next;
        root_reg  <= root_next;
        spd_reg   <= spd_next;
        scale_reg <= scale_next;
        fq_reg    <= fq_next;
        frem_reg  <= frem_next;
        v_reg     <= v_next;
        snap_reg  <= snap_next;
        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
    end

    assign done  = done_reg;
    assign new_x = res_x_reg;
    assign new_y = res_y_reg;

endmodule

/* src/pan_follow_step_unit.sv */
`timescale 1ns / 1ps

// Follow camera step unit. Jump, shift and retarget requests return the position in the
// cycle after they are accepted. A tick request runs through a bit-serial datapath that
// resolves one bit per cycle: the squares of the axis distances, an integer square root,
// the scale by follow speed, the division by the frame rate, the per-axis product and
// the per-axis division by the distance. A tick whose target lies within one pixel
// snaps to it after the squares. No new request is taken while a tick is in flight;
// a tick may be taken while the previous result still waits at the output.

module pan_follow_step_unit import pfs_pkg::*; #(
    parameter int FRAME_RATE = 60
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              operation,
    input  logic signed [POS_W-1:0] coord_x,
    input  logic signed [POS_W-1:0] coord_y,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [SPEED_W-1:0]      cfg_data
);

    ctl_state_t state_reg, state_next;

    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [POS_W-1:0]   cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [POS_W-1:0]   goal_x_reg, goal_x_next, goal_y_reg, goal_y_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;

    op_t              op;
    logic             out_free, accept, start_tick, publish, load_out;
    logic [DIFF_W-1:0] shift_x, shift_y;
    logic [POS_W-1:0] sat_x, sat_y;
    logic             tick_done;
    logic signed [POS_W-1:0] tick_x, tick_y;

    assign op       = op_t'(operation);
    assign out_free = !out_valid_reg || !out_stall;

    assign shift_x = {cur_x_reg[POS_W-1], cur_x_reg} + {coord_x[POS_W-1], coord_x};
    assign shift_y = {cur_y_reg[POS_W-1], cur_y_reg} + {coord_y[POS_W-1], coord_y};
    assign sat_x   = (shift_x[DIFF_W-1] != shift_x[POS_W-1])
                   ? (shift_x[DIFF_W-1] ? POS_MIN : POS_MAX) : shift_x[POS_W-1:0];
    assign sat_y   = (shift_y[DIFF_W-1] != shift_y[POS_W-1])
                   ? (shift_y[DIFF_W-1] ? POS_MIN : POS_MAX) : shift_y[POS_W-1:0];

    pfs_tick #(
        .FRAME_RATE (FRAME_RATE)
    ) u_tick (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_tick),
        .cur_x  (cur_x_reg),
        .cur_y  (cur_y_reg),
        .goal_x (goal_x_reg),
        .goal_y (goal_y_reg),
        .speed  (speed_reg),
        .done   (tick_done),
        .new_x  (tick_x),
        .new_y  (tick_y)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_TICK)
                begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK:
            begin
                if (tick_done)
                begin
                    state_next = out_free ? ST_IDLE : ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = !(state_reg == ST_IDLE && (out_free || op == OP_TICK));
        accept      = in_valid && !in_stall;
        start_tick  = accept && op == OP_TICK;
        publish     = out_free && ((state_reg == ST_TICK && tick_done) ||
                                   state_reg == ST_PUBLISH);
        load_out    = publish || (accept && op != OP_TICK);
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        if (publish)
        begin
            cur_x_next = tick_x;
            cur_y_next = tick_y;
            pos_x_next = tick_x;
            pos_y_next = tick_y;
        end
        else if (accept)
        begin
            unique case (op)
                OP_JUMP:
                begin
                    cur_x_next  = coord_x;
                    cur_y_next  = coord_y;
                    goal_x_next = coord_x;
                    goal_y_next = coord_y;
                    pos_x_next  = coord_x;
                    pos_y_next  = coord_y;
                end
                OP_SHIFT:
                begin
                    cur_x_next  = sat_x;
                    cur_y_next  = sat_y;
                    goal_x_next = sat_x;
                    goal_y_next = sat_y;
                    pos_x_next  = sat_x;
                    pos_y_next  = sat_y;
                end
                OP_RETARGET:
                begin
                    goal_x_next = coord_x;
                    goal_y_next = coord_y;
                    pos_x_next  = cur_x_reg;
                    pos_y_next  = cur_y_reg;
                end
                default:
                begin
                    cur_x_next = cur_x_reg;
                end
            endcase
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
        speed_next = speed_reg;
        if (cfg_valid)
        begin
            speed_next = (cfg_data > SPEED_ONE) ? SPEED_ONE : cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            speed_reg     <= SPEED_ONE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
            speed_reg     <= speed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;

endmodule

/* test/pfs_follow_check.sv */
`timescale 1ns / 1ps

module pfs_follow_check import pfs_pkg::*; #(
    parameter int FRAME_RATE = 60
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [1:0]              operation,
    input  logic signed [POS_W-1:0] coord_x,
    input  logic signed [POS_W-1:0] coord_y,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [SPEED_W-1:0]      cfg_data,
    output int                      fail_count,
    output int                      positions_due
);

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } point_t;

    point_t                  predicted_pos[$];
    logic signed [POS_W-1:0] cam_x, cam_y, aim_x, aim_y;
    logic [SPEED_W-1:0]      speed;

    function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
        if (v > longint'(8388607))
            return POS_MAX;
        if (v < longint'(-8388608))
            return POS_MIN;
        return v[POS_W-1:0];
    endfunction

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= n)
                r = trial;
        end
        return r;
    endfunction

    function automatic void follow_step(op_t op, logic signed [POS_W-1:0] x,
                                       logic signed [POS_W-1:0] y);
        longint          dx, dy, sx, sy;
        longint unsigned ax, ay, dist2, span, vel;
        case (op)
            OP_TICK:
            begin
                dx    = longint'(aim_x) - longint'(cam_x);
                dy    = longint'(aim_y) - longint'(cam_y);
                ax    = (dx < 0) ? -dx : dx;
                ay    = (dy < 0) ? -dy : dy;
                dist2 = ax * ax + ay * ay;
                if (dist2 <= 64'd65536)
                begin
                    cam_x = aim_x;
                    cam_y = aim_y;
                end
                else
                begin
                    span = floor_root(dist2);
                    vel  = ((span * 64'(speed)) / 64'(FRAME_RATE)) >> 16;
                    if (vel < 64'd256)
                        vel = 64'd256;
                    sx    = longint'((ax * vel) / span);
                    sy    = longint'((ay * vel) / span);
                    cam_x = clamp_pos(longint'(cam_x) + ((dx < 0) ? -sx : sx));
                    cam_y = clamp_pos(longint'(cam_y) + ((dy < 0) ? -sy : sy));
                end
            end
            OP_JUMP:
            begin
                cam_x = x;
                cam_y = y;
                aim_x = x;
                aim_y = y;
            end
            OP_SHIFT:
            begin
                cam_x = clamp_pos(longint'(cam_x) + longint'(x));
                cam_y = clamp_pos(longint'(cam_y) + longint'(y));
                aim_x = cam_x;
                aim_y = cam_y;
            end
            default:
            begin
                aim_x = x;
                aim_y = y;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        point_t want;
        if (!rst_n)
        begin
            cam_x = '0;
            cam_y = '0;
            aim_x = '0;
            aim_y = '0;
            speed = SPEED_ONE;
            predicted_pos.delete();
            positions_due <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                speed = (cfg_data > SPEED_ONE) ? SPEED_ONE : cfg_data;
            if (out_valid && !out_stall)
            begin
                if (predicted_pos.size() == 0)
                begin
                    $error("position %0d, %0d returned with no request outstanding",
                           pos_x, pos_y);
                    fail_count++;
                end
                else
                begin
                    want = predicted_pos.pop_front();
                    if (pos_x !== want.x)
                    begin
                        $error("pos_x: expected %0d, actual %0d", want.x, pos_x);
                        fail_count++;
                    end
                    if (pos_y !== want.y)
                    begin
                        $error("pos_y: expected %0d, actual %0d", want.y, pos_y);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                follow_step(op_t'(operation), coord_x, coord_y);
                predicted_pos.push_back('{cam_x, cam_y});
            end
            positions_due <= predicted_pos.size();
        end
    end

endmodule

/* test/pan_follow_step_unit_test.sv */
`timescale 1ns / 1ps

module pan_follow_step_unit_test;
    import pfs_pkg::*;

    localparam int RATE = 60;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              operation;
    logic signed [POS_W-1:0] coord_x;
    logic signed [POS_W-1:0] coord_y;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [SPEED_W-1:0]      cfg_data;
    int                      fail_count;
    int                      positions_due;
    int                      requests_sent;
    bit                      quiet;

    pan_follow_step_unit #(
        .FRAME_RATE(RATE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pfs_follow_check #(
        .FRAME_RATE(RATE)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .positions_due (positions_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int idle_cycles();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic signed [POS_W-1:0] rand_coord();
        return POS_W'($urandom());
    endfunction

    function automatic logic signed [POS_W-1:0] near_coord(logic signed [POS_W-1:0] base);
        longint v;
        case ($urandom_range(0, 3))
            0:       v = longint'(base) + int'($urandom_range(0, 2048)) - 1024;
            1:       v = longint'(base) + int'($urandom_range(0, 131072)) - 65536;
            2:       v = longint'(base) + int'($urandom_range(0, 2097152)) - 1048576;
            default: return rand_coord();
        endcase
        if (v > longint'(8388607))
            return POS_MAX;
        if (v < longint'(-8388608))
            return POS_MIN;
        return v[POS_W-1:0];
    endfunction

    // hold the request until accepted; drop valid only when a gap follows
    task automatic send_request(op_t op, logic signed [POS_W-1:0] x,
                                logic signed [POS_W-1:0] y);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid  <= 1'b0;
            operation <= 2'($urandom());
            coord_x   <= rand_coord();
            coord_y   <= rand_coord();
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        coord_x   <= x;
        coord_y   <= y;
        do @(posedge clk); while (in_stall);
        requests_sent++;
    endtask

    task automatic wait_until_settled();
        in_valid <= 1'b0;
        do @(posedge clk); while (positions_due != 0);
    endtask

    task automatic write_speed(logic [SPEED_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int stall_len;
        out_stall = 1'b0;
        forever
        begin
            repeat ($urandom_range(1, 24)) @(posedge clk);
            stall_len = idle_cycles();
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        logic [SPEED_W-1:0]      speeds[6];
        logic signed [POS_W-1:0] base_x, base_y;
        int                      pick;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_TICK;
        coord_x       = '0;
        coord_y       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        quiet         = 1'b0;
        requests_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass at the reset speed
        send_request(OP_TICK, rand_coord(), rand_coord());
        send_request(OP_JUMP, POS_MAX, POS_MIN);
        send_request(OP_SHIFT, POS_MAX, POS_MIN);
        send_request(OP_SHIFT, POS_MIN, POS_MAX);
        send_request(OP_JUMP, POS_MIN, POS_MAX);
        send_request(OP_SHIFT, POS_MIN, POS_MAX);
        send_request(OP_JUMP, '0, '0);
        send_request(OP_RETARGET, 24'sd256, '0);
        send_request(OP_TICK, POS_MAX, POS_MIN);
        send_request(OP_RETARGET, 24'sd513, '0);
        send_request(OP_TICK, POS_MIN, POS_MAX);
        send_request(OP_TICK, '1, '1);
        send_request(OP_JUMP, '0, '0);
        send_request(OP_RETARGET, 24'sd181, 24'sd181);
        send_request(OP_TICK, '0, '0);
        send_request(OP_RETARGET, -24'sd300, -24'sd5);
        send_request(OP_TICK, '0, '0);
        send_request(OP_TICK, '0, '0);
        send_request(OP_JUMP, POS_MAX, POS_MAX);
        send_request(OP_RETARGET, POS_MIN, POS_MIN);
        send_request(OP_TICK, '0, '0);
        send_request(OP_TICK, '0, '0);
        send_request(OP_TICK, '0, '0);
        wait_until_settled();

        speeds = '{17'd0, 17'h1FFFF, SPEED_ONE, 17'd1, 17'd70000,
                   SPEED_W'($urandom_range(0, 65536))};
        foreach (speeds[p])
        begin
            write_speed(speeds[p]);
            quiet = (p == 2);
            requests_sent = 0;
            while (requests_sent < 250)
            begin
                if ($urandom_range(0, 39) == 0)
                    wait_until_settled();
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    base_x = rand_coord();
                    base_y = rand_coord();
                    if ($urandom_range(0, 2) != 0)
                        send_request(OP_JUMP, base_x, base_y);
                    send_request(OP_RETARGET, near_coord(base_x), near_coord(base_y));
                    repeat ($urandom_range(1, 10))
                        send_request(OP_TICK, rand_coord(), rand_coord());
                end
                else if (pick == 6)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_request(OP_SHIFT, near_coord('0), near_coord('0));
                    else
                        send_request(OP_SHIFT, rand_coord(), rand_coord());
                end
                else if (pick == 7)
                    send_request(OP_JUMP, rand_coord(), rand_coord());
                else if (pick == 8)
                    send_request(OP_TICK, rand_coord(), rand_coord());
                else
                    send_request(OP_RETARGET, rand_coord(), rand_coord());
            end
            wait_until_settled();
        end

        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
